/* hdl/sorted_table_binary_search_core_defines.svh */
// Assertion macros shared by the checker of the sorted table search core.
// Depends on nothing; included by the checker file.
`ifndef SORTED_TABLE_BINARY_SEARCH_CORE_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SBS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbs check failed");

// Next-cycle implication, disabled while reset is high.
`define SBS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbs check failed");

// Next-cycle implication that also holds across reset.
`define SBS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sbs check failed");

`endif

/* hdl/sbs_pkg.sv */
// Shared constants for the sorted table search core.
// No dependencies; imported by every other file of the block but the defines header.
package sbs_pkg;

  localparam int FUNC_W  = 1;
  localparam int INDEX_W = 10;
  localparam int KEY_W   = 64;
  localparam int POS_W   = 10;
  localparam int COUNT_W = 11;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Function codes of a command item.
  localparam logic [FUNC_W-1:0] FUNC_WRITE  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 1'b1;

  // Register word index, taken from paddr above the byte bits.
  localparam logic [APB_ADDR_W-3:0] REG_WORD_COUNT = 1'b0;

endpackage

/* hdl/sbs_if.sv */
// Valid/ready channel interfaces for commands and search responses.
// Depends on sbs_pkg for the field widths.
interface sbs_cmd_if;
  import sbs_pkg::*;
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [INDEX_W-1:0] index;
  logic [KEY_W-1:0]   key;

  modport source (output valid, func, index, key, input ready);
  modport sink (input valid, func, index, key, output ready);
endinterface

interface sbs_rsp_if;
  import sbs_pkg::*;
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;

  modport source (output valid, found, position, input ready);
  modport sink (input valid, found, position, output ready);
endinterface

/* hdl/sorted_table_binary_search_core.sv */
// Top level of the sorted table binary search core.
// Depends on sbs_pkg, sbs_if, sbs_mem, sbs_cfg and sbs_ctrl.
//
//   Channel   Role     Transfer carries
//   cmd       sink     func, index, key (write an entry or look up a key)
//   rsp       source   found, position (one per lookup, none per write)
//   apb       slave    word_count register at byte address 0
//
// A write transfer stores the key at the edge that accepts it. A lookup
// makes at most P = ceil(log2(n + 1)) probes over n = min(word_count,
// TABLE_DEPTH) entries, fewer when the key is found early: the single read
// port of the table memory allows one probe per cycle.
// Synchronous reset clears the sequencer, the response valid and word_count;
// the table itself is not cleared and must be written before it is searched.
// A stalled response holds its output register; the next command is taken
// while that result still waits, and a following lookup waits in its final
// cycle until the output register is free.
module sorted_table_binary_search_core #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  sbs_cmd_if.sink                       cmd,
  sbs_rsp_if.source                     rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sbs_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sbs_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sbs_pkg::APB_DATA_W-1:0] prdata,
  output logic                          pready
);
  import sbs_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [COUNT_W-1:0] word_count;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [KEY_W-1:0]   wr_data;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [KEY_W-1:0]   rd_data;

  // Register block: the user must change word_count only while no lookup is running; the block does not enforce it.
  sbs_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .word_count (word_count)
  );

  // Sequencer: accepts commands, walks the probe loop, owns the result.
  sbs_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .word_count (word_count),
    .cmd        (cmd),
    .rsp        (rsp),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  // Table memory: the read issued in one cycle is compared in the next.
  sbs_mem #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

/* hdl/sbs_mem.sv */
// Word table storage: one write port, one read port, registered read data.
// Depends on sbs_pkg for the key width.
module sbs_mem #(
  parameter int TABLE_DEPTH = 1024,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic [sbs_pkg::KEY_W-1:0] wr_data,
  input  logic                    rd_en,
  input  logic [AW-1:0]           rd_addr,
  output logic [sbs_pkg::KEY_W-1:0] rd_data
);
  import sbs_pkg::*;

  logic [KEY_W-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/sbs_cfg.sv */
// APB register block holding the word_count register.
// Depends on sbs_pkg for register index and widths.
module sbs_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sbs_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [sbs_pkg::APB_DATA_W-1:0] pwdata,
  output logic [sbs_pkg::APB_DATA_W-1:0] prdata,
  output logic                          pready,
  output logic [sbs_pkg::COUNT_W-1:0]    word_count
);
  import sbs_pkg::*;

  logic wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && pready &&
                  (paddr[APB_ADDR_W-1:2] == REG_WORD_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= '0;
    end else if (wr_hit) begin
      word_count <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    if (paddr[APB_ADDR_W-1:2] == REG_WORD_COUNT) begin
      prdata = APB_DATA_W'(word_count);
    end else begin
      prdata = '0;
    end
  end

endmodule

/* hdl/sbs_ctrl.sv */
// Command sequencer: table writes and the probe loop of a lookup.
// Depends on sbs_pkg and the channel interfaces; drives the table memory.
module sbs_ctrl #(
  parameter int TABLE_DEPTH = 1024,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int NW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [sbs_pkg::COUNT_W-1:0] word_count,
  sbs_cmd_if.sink                   cmd,
  sbs_rsp_if.source                 rsp,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output logic [sbs_pkg::KEY_W-1:0] wr_data,
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  input  logic [sbs_pkg::KEY_W-1:0] rd_data
);
  import sbs_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_FINISH} state_t;

  state_t           state;
  logic [KEY_W-1:0] key_q;
  logic [NW-1:0]    low;
  logic [NW-1:0]    hi_excl;   // one past the inclusive upper bound
  logic [NW-1:0]    mid;
  logic             hit;

  logic [NW-1:0]    used;
  logic [NW-1:0]    first_mid;
  logic [NW:0]      sum_lo;
  logic [NW:0]      sum_hi;
  logic [NW-1:0]    mid_lo;
  logic [NW-1:0]    mid_hi;
  logic [NW-1:0]    mid_p1;
  logic             key_eq;
  logic             key_lt;
  logic             done_lt;
  logic             done_gt;
  logic             start;
  logic             rsp_load;

  always_comb begin
    if (32'(word_count) > 32'(TABLE_DEPTH)) begin
      used = NW'(TABLE_DEPTH);
    end else begin
      used = NW'(word_count);
    end
  end

  assign first_mid = (used - 1'b1) >> 1;

  // Both possible next midpoints are formed from registered bounds while
  // the key compare runs, so the compare only selects between them.
  assign sum_lo  = {1'b0, low} + {1'b0, mid} - 1'b1;
  assign sum_hi  = {1'b0, mid} + {1'b0, hi_excl};
  assign mid_lo  = sum_lo[NW:1];
  assign mid_hi  = sum_hi[NW:1];
  assign mid_p1  = mid + 1'b1;
  assign key_eq  = (key_q == rd_data);
  assign key_lt  = (key_q < rd_data);
  assign done_lt = (low >= mid);
  assign done_gt = (mid_p1 >= hi_excl);

  assign cmd.ready = (state == ST_IDLE);
  assign start     = cmd.valid && (state == ST_IDLE) && (cmd.func == FUNC_SEARCH);

  // The output register takes a new result when it is empty or being drained.
  assign rsp_load  = (state == ST_FINISH) && (!rsp.valid || rsp.ready);

  assign wr_en   = cmd.valid && (state == ST_IDLE) && (cmd.func == FUNC_WRITE) &&
                   (32'(cmd.index) < 32'(TABLE_DEPTH));
  assign wr_addr = AW'(cmd.index);
  assign wr_data = cmd.key;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = AW'(first_mid);
    if (state == ST_IDLE) begin
      rd_en = start && (used != '0);
    end else if (state == ST_SEARCH) begin
      rd_en   = !key_eq && (key_lt ? !done_lt : !done_gt);
      rd_addr = key_lt ? AW'(mid_lo) : AW'(mid_hi);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && !rsp_load) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            key_q   <= cmd.key;
            low     <= '0;
            hi_excl <= used;
            mid     <= first_mid;
            hit     <= 1'b0;
            state   <= (used == '0) ? ST_FINISH : ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (key_eq) begin
            hit   <= 1'b1;
            state <= ST_FINISH;
          end else if (key_lt) begin
            hi_excl <= mid;
            mid     <= mid_lo;
            if (done_lt) begin
              state <= ST_FINISH;
            end
          end else begin
            low <= mid_p1;
            mid <= mid_hi;
            if (done_gt) begin
              state <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (rsp_load) begin
            rsp.valid    <= 1'b1;
            rsp.found    <= hit;
            rsp.position <= hit ? POS_W'(mid) : '0;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/sbs_checker.sv */
// Port-level checks for the sorted table search core, bound to the top.
// Depends on sbs_pkg and sorted_table_binary_search_core_defines.svh.
`include "sorted_table_binary_search_core_defines.svh"

module sbs_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     cmd_valid,
  input logic                     cmd_ready,
  input logic [sbs_pkg::FUNC_W-1:0] cmd_func,
  input logic                     rsp_valid,
  input logic                     rsp_ready,
  input logic                     rsp_found,
  input logic [sbs_pkg::POS_W-1:0] rsp_position
);
  import sbs_pkg::*;

  `SBS_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_found) && $stable(rsp_position))
  `SBS_ASSERT_NOW(a_miss_pos_zero, clk, rst, rsp_valid && !rsp_found, rsp_position == '0)
  `SBS_ASSERT_NEXT(a_search_busy, clk, rst, cmd_valid && cmd_ready && (cmd_func == FUNC_SEARCH), !cmd_ready)
  `SBS_ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, rst, !rsp_valid)

endmodule

bind sorted_table_binary_search_core sbs_checker u_sbs_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .cmd_func     (cmd.func),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_found    (rsp.found),
  .rsp_position (rsp.position)
);
